// File: hw/rtl/twdsl_pkg.sv
// Shared widths, codes, command type and constants of the two-wheel drive speed loop.
package twdsl_pkg;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  localparam logic [CFG_IDX_W-1:0] REG_MAX_SPEED     = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SLEW_THRESH   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_LAG_GAIN      = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_POWER_LOW     = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_POWER_HIGH    = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_REDUCED_SCALE = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_P_GAIN        = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_OUT_LIMIT     = 3'd7;

  localparam logic [13:0] RST_MAX_SPEED     = 14'd8000;
  localparam logic [13:0] RST_SLEW_THRESH   = 14'd1000;
  localparam logic [15:0] RST_LAG_GAIN      = 16'd1311;
  localparam logic [9:0]  RST_POWER_LOW     = 10'd30;
  localparam logic [9:0]  RST_POWER_HIGH    = 10'd80;
  localparam logic [15:0] RST_REDUCED_SCALE = 16'd19661;
  localparam logic [7:0]  RST_P_GAIN        = 8'd5;
  localparam logic [13:0] RST_OUT_LIMIT     = 14'd3000;

  localparam logic [15:0] SCALE_ONE = 16'd32768;
  localparam logic [14:0] CURVE_HI  = 15'd18022;
  localparam logic [14:0] CURVE_LO  = 15'd15892;
  localparam logic [14:0] CURVE_ONE = 15'd16384;

  localparam logic [1:0] POS_FRONT_CURVE  = 2'd1;
  localparam logic [1:0] POS_BEHIND_CURVE = 2'd2;

  localparam logic [2:0] MUL_NONE  = 3'd0;
  localparam logic [2:0] MUL_LAG   = 3'd1;
  localparam logic [2:0] MUL_FRONT = 3'd2;
  localparam logic [2:0] MUL_BACK  = 3'd3;
  localparam logic [2:0] MUL_FCURV = 3'd4;
  localparam logic [2:0] MUL_BCURV = 3'd5;
  localparam logic [2:0] MUL_ERR   = 3'd6;

  typedef struct packed {
    logic       load;
    logic       diff_en;
    logic       target_en;
    logic [2:0] mul_op;
    logic       f_scale_en;
    logic       b_scale_en;
    logic       f_curve_en;
    logic       b_curve_en;
    logic       err_f_en;
    logic       err_b_en;
    logic       drv_f_en;
    logic       out_load;
  } dp_cmd_t;

endpackage

// File: hw/rtl/twdsl_intf.sv
// Input and output channel interfaces of the two-wheel drive speed loop.
interface twdsl_in_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] speed_command;
  logic [9:0]         buffer_level;
  logic [1:0]         track_position;
  logic signed [15:0] front_measured;
  logic signed [15:0] back_measured;

  modport source(output valid, output speed_command, output buffer_level,
                 output track_position, output front_measured, output back_measured,
                 input ready);
  modport sink(input valid, input speed_command, input buffer_level,
               input track_position, input front_measured, input back_measured,
               output ready);
endinterface

interface twdsl_out_if;
  logic               valid;
  logic               ready;
  logic signed [14:0] front_drive;
  logic signed [14:0] back_drive;
  logic               limiting_active;

  modport source(output valid, output front_drive, output back_drive,
                 output limiting_active, input ready);
  modport sink(input valid, input front_drive, input back_drive,
               input limiting_active, output ready);
endinterface

// File: hw/rtl/twdsl_ctrl.sv
// Step sequencer of the speed loop: issues datapath commands and owns the handshakes.
module twdsl_ctrl import twdsl_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  logic    in_valid,
  output logic    in_ready,
  output logic    out_valid,
  input  logic    out_ready,
  output dp_cmd_t cmd
);

  localparam logic [3:0] ST_IDLE = 4'd0;
  localparam logic [3:0] ST_DIFF = 4'd1;
  localparam logic [3:0] ST_MLAG = 4'd2;
  localparam logic [3:0] ST_TGT  = 4'd3;
  localparam logic [3:0] ST_MF   = 4'd4;
  localparam logic [3:0] ST_MB   = 4'd5;
  localparam logic [3:0] ST_CF   = 4'd6;
  localparam logic [3:0] ST_CB   = 4'd7;
  localparam logic [3:0] ST_EF   = 4'd8;
  localparam logic [3:0] ST_MEF  = 4'd9;
  localparam logic [3:0] ST_MEB  = 4'd10;
  localparam logic [3:0] ST_FIN  = 4'd11;

  logic [3:0] state;
  logic [3:0] state_next;

  assign in_ready = (state == ST_IDLE);

  always_comb begin
    state_next = state;
    cmd        = '0;
    cmd.mul_op = MUL_NONE;
    case (state)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = ST_DIFF;
        end
      end
      ST_DIFF: begin
        cmd.diff_en = 1'b1;
        state_next  = ST_MLAG;
      end
      ST_MLAG: begin
        cmd.mul_op = MUL_LAG;
        state_next = ST_TGT;
      end
      ST_TGT: begin
        cmd.target_en = 1'b1;
        state_next    = ST_MF;
      end
      ST_MF: begin
        cmd.mul_op = MUL_FRONT;
        state_next = ST_MB;
      end
      ST_MB: begin
        cmd.f_scale_en = 1'b1;
        cmd.mul_op     = MUL_BACK;
        state_next     = ST_CF;
      end
      ST_CF: begin
        cmd.b_scale_en = 1'b1;
        cmd.mul_op     = MUL_FCURV;
        state_next     = ST_CB;
      end
      ST_CB: begin
        cmd.f_curve_en = 1'b1;
        cmd.mul_op     = MUL_BCURV;
        state_next     = ST_EF;
      end
      ST_EF: begin
        cmd.b_curve_en = 1'b1;
        cmd.err_f_en   = 1'b1;
        state_next     = ST_MEF;
      end
      ST_MEF: begin
        cmd.mul_op   = MUL_ERR;
        cmd.err_b_en = 1'b1;
        state_next   = ST_MEB;
      end
      ST_MEB: begin
        cmd.drv_f_en = 1'b1;
        cmd.mul_op   = MUL_ERR;
        state_next   = ST_FIN;
      end
      ST_FIN: begin
        // hold until the output word slot is free
        if (!out_valid || out_ready) begin
          cmd.out_load = 1'b1;
          state_next   = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.out_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

// File: hw/rtl/twdsl_dp.sv
// Datapath of the speed loop: settings, target state, shared multiplier and output word.
module twdsl_dp import twdsl_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  wr_en,
  input  logic [CFG_IDX_W-1:0]  wr_index,
  input  logic [CFG_DATA_W-1:0] wr_data,
  input  dp_cmd_t               cmd,
  input  logic signed [15:0]    speed_command,
  input  logic [9:0]            buffer_level,
  input  logic [1:0]            track_position,
  input  logic signed [15:0]    front_measured,
  input  logic signed [15:0]    back_measured,
  output logic signed [14:0]    front_drive,
  output logic signed [14:0]    back_drive,
  output logic                  limiting_active
);

  logic [13:0] max_speed;
  logic [13:0] slew_threshold;
  logic [15:0] lag_gain;
  logic [9:0]  power_low;
  logic [9:0]  power_high;
  logic [15:0] reduced_scale;
  logic [7:0]  p_gain;
  logic [13:0] out_limit;

  logic               limited;
  logic               limited_next;
  logic signed [31:0] target;
  logic signed [14:0] cmd_q;
  logic [1:0]         pos_q;
  logic signed [15:0] fm_q;
  logic signed [15:0] bm_q;
  logic signed [32:0] diff;
  logic               lag;
  logic signed [53:0] prod;
  logic signed [35:0] f_val;
  logic signed [35:0] b_val;
  logic signed [35:0] err;
  logic signed [14:0] drv_f;

  logic signed [16:0] cmd_ext;
  logic signed [16:0] lim_ext;
  logic signed [16:0] cmd_clamp;
  logic signed [32:0] diff_c;
  logic signed [32:0] thr_s;
  logic signed [31:0] cmd_q16;
  logic [15:0]        scale;
  logic [14:0]        curve_f;
  logic [14:0]        curve_b;
  logic signed [35:0] mul_a;
  logic signed [17:0] mul_b;
  logic signed [53:0] mul_p;
  logic signed [14:0] sat_p;

  function automatic logic signed [14:0] sat_drive(input logic signed [37:0] v,
                                                   input logic [13:0] lim);
    logic signed [37:0] hi;
    hi = $signed({24'd0, lim});
    if (v > hi) begin
      sat_drive = hi[14:0];
    end else if (v < -hi) begin
      sat_drive = 15'(-hi);
    end else begin
      sat_drive = v[14:0];
    end
  endfunction

  always_ff @(posedge clk) begin
    if (rst) begin
      max_speed      <= RST_MAX_SPEED;
      slew_threshold <= RST_SLEW_THRESH;
      lag_gain       <= RST_LAG_GAIN;
      power_low      <= RST_POWER_LOW;
      power_high     <= RST_POWER_HIGH;
      reduced_scale  <= RST_REDUCED_SCALE;
      p_gain         <= RST_P_GAIN;
      out_limit      <= RST_OUT_LIMIT;
    end else if (wr_en) begin
      case (wr_index)
        REG_MAX_SPEED:     max_speed      <= wr_data[13:0];
        REG_SLEW_THRESH:   slew_threshold <= wr_data[13:0];
        REG_LAG_GAIN:      lag_gain       <= wr_data[15:0];
        REG_POWER_LOW:     power_low      <= wr_data[9:0];
        REG_POWER_HIGH:    power_high     <= wr_data[9:0];
        REG_REDUCED_SCALE: reduced_scale  <= wr_data[15:0];
        REG_P_GAIN:        p_gain         <= wr_data[7:0];
        REG_OUT_LIMIT:     out_limit      <= wr_data[13:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    limited_next = limited | (buffer_level < power_low);
    if (limited_next && (buffer_level > power_high)) begin
      limited_next = 1'b0;
    end
    cmd_ext = 17'(speed_command);
    lim_ext = $signed({3'd0, max_speed});
    if (cmd_ext > lim_ext) begin
      cmd_clamp = lim_ext;
    end else if (cmd_ext < -lim_ext) begin
      cmd_clamp = -lim_ext;
    end else begin
      cmd_clamp = cmd_ext;
    end
  end

  assign cmd_q16 = 32'($signed({cmd_q, 16'h0000}));
  assign diff_c  = 33'(cmd_q16) - 33'(target);
  assign thr_s   = $signed({3'd0, slew_threshold, 16'h0000});
  assign scale   = limited ? reduced_scale : SCALE_ONE;

  always_comb begin
    case (pos_q)
      POS_FRONT_CURVE: begin
        curve_f = CURVE_HI;
        curve_b = CURVE_LO;
      end
      POS_BEHIND_CURVE: begin
        curve_f = CURVE_LO;
        curve_b = CURVE_HI;
      end
      default: begin
        curve_f = CURVE_ONE;
        curve_b = CURVE_ONE;
      end
    endcase
  end

  always_comb begin
    case (cmd.mul_op)
      MUL_LAG: begin
        mul_a = 36'(diff);
        mul_b = $signed({2'd0, lag_gain});
      end
      MUL_FRONT: begin
        mul_a = -36'(target);
        mul_b = $signed({2'd0, scale});
      end
      MUL_BACK: begin
        mul_a = 36'(target);
        mul_b = $signed({2'd0, scale});
      end
      MUL_FCURV: begin
        mul_a = f_val;
        mul_b = $signed({3'd0, curve_f});
      end
      MUL_BCURV: begin
        mul_a = b_val;
        mul_b = $signed({3'd0, curve_b});
      end
      MUL_ERR: begin
        mul_a = err;
        mul_b = $signed({10'd0, p_gain});
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign mul_p = mul_a * mul_b;
  assign sat_p = sat_drive($signed(prod[53:16]), out_limit);

  always_ff @(posedge clk) begin
    if (rst) begin
      limited <= 1'b0;
      target  <= '0;
    end else begin
      if (cmd.load) begin
        limited <= limited_next;
      end
      if (cmd.target_en) begin
        target <= lag ? target + $signed(prod[47:16]) : cmd_q16;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      cmd_q <= cmd_clamp[14:0];
      pos_q <= track_position;
      fm_q  <= front_measured;
      bm_q  <= back_measured;
    end
    if (cmd.diff_en) begin
      diff <= diff_c;
      lag  <= (diff_c > thr_s) || (diff_c < -thr_s);
    end
    if (cmd.mul_op != MUL_NONE) begin
      prod <= mul_p;
    end
    if (cmd.f_scale_en) begin
      f_val <= $signed(prod[50:15]);
    end else if (cmd.f_curve_en) begin
      f_val <= $signed(prod[49:14]);
    end
    if (cmd.b_scale_en) begin
      b_val <= $signed(prod[50:15]);
    end else if (cmd.b_curve_en) begin
      b_val <= $signed(prod[49:14]);
    end
    if (cmd.err_f_en) begin
      err <= f_val - 36'($signed({fm_q, 16'h0000}));
    end else if (cmd.err_b_en) begin
      err <= b_val - 36'($signed({bm_q, 16'h0000}));
    end
    if (cmd.drv_f_en) begin
      drv_f <= sat_p;
    end
    if (cmd.out_load) begin
      front_drive     <= drv_f;
      back_drive      <= sat_p;
      limiting_active <= limited;
    end
  end

endmodule

// File: hw/rtl/two_wheel_drive_speed_loop.sv
// Top level of the two-wheel drive speed loop: sequencer plus datapath.
//
//   channel     dir  handshake     word
//   drive_in    in   valid/ready   speed_command, buffer_level, track_position,
//                                  front_measured, back_measured
//   drive_out   out  valid/ready   front_drive, back_drive, limiting_active
//   wr_*        in   wr_en only    wr_index, wr_data (settings)
//
// Each word passes through the sequencer steps in order, and a new word is taken
// only once the last one has been loaded into the output word: seven products pass
// one after another through a single shared 36x18 multiplier.
// Reset is synchronous; settings return to their defaults, target and flag clear.
// A result holds on drive_out until taken; the next word is accepted meanwhile,
// and its last step waits for the output slot.
module two_wheel_drive_speed_loop import twdsl_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  wr_en,
  input  logic [CFG_IDX_W-1:0]  wr_index,
  input  logic [CFG_DATA_W-1:0] wr_data,
  twdsl_in_if.sink              drive_in,
  twdsl_out_if.source           drive_out
);

  dp_cmd_t cmd;

  twdsl_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (drive_in.valid),
    .in_ready  (drive_in.ready),
    .out_valid (drive_out.valid),
    .out_ready (drive_out.ready),
    .cmd       (cmd)
  );

  twdsl_dp u_dp (
    .clk             (clk),
    .rst             (rst),
    .wr_en           (wr_en),
    .wr_index        (wr_index),
    .wr_data         (wr_data),
    .cmd             (cmd),
    .speed_command   (drive_in.speed_command),
    .buffer_level    (drive_in.buffer_level),
    .track_position  (drive_in.track_position),
    .front_measured  (drive_in.front_measured),
    .back_measured   (drive_in.back_measured),
    .front_drive     (drive_out.front_drive),
    .back_drive      (drive_out.back_drive),
    .limiting_active (drive_out.limiting_active)
  );

endmodule

// File: hw/rtl/twdsl_chk.sv
// Port-level checker of the speed loop and its bind to the top level.
module twdsl_chk (
  input logic               clk,
  input logic               rst,
  input logic               in_valid,
  input logic               in_ready,
  input logic               out_valid,
  input logic               out_ready,
  input logic signed [14:0] front_drive,
  input logic signed [14:0] back_drive,
  input logic               limiting_active
);

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid)
    else $error("output word dropped while stalled");

  a_out_stable: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> $stable(front_drive) && $stable(back_drive)
                                && $stable(limiting_active))
    else $error("output word changed while stalled");

  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready && !$rose(out_valid))
    else $error("second word taken or result too early");

  a_reset_idle: assert property (@(posedge clk)
    rst |=> in_ready && !out_valid)
    else $error("not idle after reset");

endmodule

bind two_wheel_drive_speed_loop twdsl_chk u_chk (
  .clk             (clk),
  .rst             (rst),
  .in_valid        (drive_in.valid),
  .in_ready        (drive_in.ready),
  .out_valid       (drive_out.valid),
  .out_ready       (drive_out.ready),
  .front_drive     (drive_out.front_drive),
  .back_drive      (drive_out.back_drive),
  .limiting_active (drive_out.limiting_active)
);

// File: tb/tb_two_wheel_drive_speed_loop.sv
// Self-checking testbench for the two-wheel drive speed loop: directed and random words.
`timescale 1ns / 100ps

module tb_two_wheel_drive_speed_loop;
  import twdsl_pkg::*;

  localparam logic [1:0] POS_STRAIGHT = 2'd0;
  localparam logic [1:0] POS_UNUSED   = 2'd3;
  localparam int LATENCY      = 11;
  localparam int CYCLE_LIMIT  = 500000;
  localparam int RAND_PHASES  = 14;
  localparam int PHASE_WORDS  = 100;

  typedef struct {
    logic [13:0] max_speed;
    logic [13:0] slew;
    logic [15:0] lag_gain;
    logic [9:0]  pwr_low;
    logic [9:0]  pwr_high;
    logic [15:0] red_scale;
    logic [7:0]  p_gain;
    logic [13:0] out_limit;
  } loop_cfg_t;

  typedef struct {
    logic signed [14:0] front;
    logic signed [14:0] back;
    logic               limiting;
  } drive_result_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic                  wr_en;
  logic [CFG_IDX_W-1:0]  wr_index;
  logic [CFG_DATA_W-1:0] wr_data;

  twdsl_in_if  drive_in_if();
  twdsl_out_if drive_out_if();

  two_wheel_drive_speed_loop u_dut (
    .clk       (clk),
    .rst       (rst),
    .wr_en     (wr_en),
    .wr_index  (wr_index),
    .wr_data   (wr_data),
    .drive_in  (drive_in_if),
    .drive_out (drive_out_if)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  loop_cfg_t     cfg;
  int            tgt_q16;
  logic          limited;
  drive_result_t pending_drives[$];
  bit            src_idle;
  bit            sink_idle;
  int            fail_cnt = 0;
  int            words_sent = 0;
  int            results_seen = 0;
  int            reg_writes = 0;
  int            cycle_cnt = 0;

  function automatic logic signed [14:0] wheel_drive(input longint t,
                                                     input logic signed [15:0] meas);
    longint v, lim;
    v = ((t - longint'(meas) * 65536) * longint'(cfg.p_gain)) >>> 16;
    lim = longint'(cfg.out_limit);
    if (v > lim) v = lim;
    if (v < -lim) v = -lim;
    return v[14:0];
  endfunction

  function automatic drive_result_t predict_tick(input logic signed [15:0] cmd_in,
                                                 input logic [9:0] lvl,
                                                 input logic [1:0] pos,
                                                 input logic signed [15:0] fm,
                                                 input logic signed [15:0] bm);
    longint cmd, lim, diff, adiff, scale, f, b;
    drive_result_t r;
    if (lvl < cfg.pwr_low) limited = 1'b1;
    if (limited && lvl > cfg.pwr_high) limited = 1'b0;
    scale = limited ? longint'(cfg.red_scale) : longint'(SCALE_ONE);

    cmd = longint'(cmd_in);
    lim = longint'(cfg.max_speed);
    if (cmd > lim) cmd = lim;
    if (cmd < -lim) cmd = -lim;
    cmd = cmd * 65536;

    diff = cmd - longint'(tgt_q16);
    adiff = (diff < 0) ? -diff : diff;
    if (adiff > longint'(cfg.slew) * 65536) begin
      tgt_q16 = int'(longint'(tgt_q16) + ((diff * longint'(cfg.lag_gain)) >>> 16));
    end else begin
      tgt_q16 = int'(cmd);
    end

    f = (-longint'(tgt_q16) * scale) >>> 15;
    b = (longint'(tgt_q16) * scale) >>> 15;
    case (pos)
      POS_FRONT_CURVE: begin
        f = (f * longint'(CURVE_HI)) >>> 14;
        b = (b * longint'(CURVE_LO)) >>> 14;
      end
      POS_BEHIND_CURVE: begin
        f = (f * longint'(CURVE_LO)) >>> 14;
        b = (b * longint'(CURVE_HI)) >>> 14;
      end
      default: ;
    endcase

    r.front = wheel_drive(f, fm);
    r.back = wheel_drive(b, bm);
    r.limiting = limited;
    return r;
  endfunction

  function automatic logic signed [15:0] sat16(input int v);
    if (v > 32767) return 16'h7fff;
    if (v < -32768) return 16'h8000;
    return v[15:0];
  endfunction

  function automatic logic [9:0] clamp_lvl(input int v);
    if (v < 0) return 10'd0;
    if (v > 1023) return 10'd1023;
    return v[9:0];
  endfunction

  function automatic logic [15:0] with_junk(input int w, input logic [15:0] v);
    logic [15:0] junk;
    junk = 16'($urandom);
    return (junk << w) | v;
  endfunction

  function automatic logic [15:0] pick_val(input logic [15:0] rst_val, input int top);
    case ($urandom_range(0, 7))
      0: return 16'd0;
      1: return top[15:0];
      2, 3: return rst_val;
      default: return 16'($urandom_range(0, top));
    endcase
  endfunction

  task automatic set_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    wr_en <= 1'b1;
    wr_index <= idx;
    wr_data <= data;
    @(posedge clk);
    case (idx)
      REG_MAX_SPEED:     cfg.max_speed = data[13:0];
      REG_SLEW_THRESH:   cfg.slew = data[13:0];
      REG_LAG_GAIN:      cfg.lag_gain = data;
      REG_POWER_LOW:     cfg.pwr_low = data[9:0];
      REG_POWER_HIGH:    cfg.pwr_high = data[9:0];
      REG_REDUCED_SCALE: cfg.red_scale = data;
      REG_P_GAIN:        cfg.p_gain = data[7:0];
      REG_OUT_LIMIT:     cfg.out_limit = data[13:0];
      default: ;
    endcase
    wr_en <= 1'b0;
    @(posedge clk);
    reg_writes++;
  endtask

  task automatic send_word(input logic signed [15:0] cmd, input logic [9:0] lvl,
                           input logic [1:0] pos, input logic signed [15:0] fm,
                           input logic signed [15:0] bm);
    int gap;
    gap = src_idle ? $urandom_range(0, 9) : 0;
    if (gap > 0) begin
      drive_in_if.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    drive_in_if.valid <= 1'b1;
    drive_in_if.speed_command <= cmd;
    drive_in_if.buffer_level <= lvl;
    drive_in_if.track_position <= pos;
    drive_in_if.front_measured <= fm;
    drive_in_if.back_measured <= bm;
    do @(posedge clk); while (!drive_in_if.ready);
    pending_drives.push_back(predict_tick(cmd, lvl, pos, fm, bm));
    words_sent++;
  endtask

  task automatic settle();
    drive_in_if.valid <= 1'b0;
    while (pending_drives.size() != 0) @(posedge clk);
  endtask

  task automatic test_default_settings();
    src_idle = 1'b0;
    sink_idle = 1'b0;
    send_word(16'sd0, 10'd1023, POS_STRAIGHT, 16'sd0, 16'sd0);
    send_word(16'h7fff, 10'd1023, POS_FRONT_CURVE, 16'h8000, 16'h7fff);
    send_word(16'h8000, 10'd0, POS_BEHIND_CURVE, 16'h7fff, 16'h8000);
    send_word(16'h8000, 10'd80, POS_UNUSED, 16'sd0, 16'sd0);
    send_word(16'h8000, 10'd81, POS_STRAIGHT, 16'sd100, -16'sd100);
    send_word(16'h8000, 10'd30, POS_FRONT_CURVE, 16'sd0, 16'sd0);
    send_word(16'h8000, 10'd29, POS_BEHIND_CURVE, 16'sd0, 16'sd0);
    settle();
  endtask

  task automatic test_crossed_thresholds();
    src_idle = 1'b1;
    sink_idle = 1'b1;
    set_reg(REG_POWER_LOW, 16'd100);
    set_reg(REG_POWER_HIGH, 16'd20);
    send_word(16'sd2000, 10'd50, POS_STRAIGHT, 16'sd1900, -16'sd1900);
    send_word(16'sd2000, 10'd10, POS_FRONT_CURVE, -16'sd1000, 16'sd1000);
    send_word(16'sd2000, 10'd50, POS_BEHIND_CURVE, 16'sd0, 16'sd0);
    send_word(-16'sd2000, 10'd500, POS_STRAIGHT, 16'sd0, 16'sd0);
    settle();
  endtask

  task automatic test_zero_limits();
    src_idle = 1'b0;
    sink_idle = 1'b1;
    set_reg(REG_MAX_SPEED, 16'd0);
    set_reg(REG_OUT_LIMIT, 16'd0);
    send_word(16'h7fff, 10'd1023, POS_STRAIGHT, 16'h8000, 16'h7fff);
    send_word(16'h8000, 10'd0, POS_FRONT_CURVE, 16'h7fff, 16'h8000);
    settle();
  endtask

  task automatic test_full_scale();
    src_idle = 1'b1;
    sink_idle = 1'b0;
    set_reg(REG_MAX_SPEED, 16'd16383);
    set_reg(REG_SLEW_THRESH, 16'd0);
    set_reg(REG_LAG_GAIN, 16'hffff);
    set_reg(REG_REDUCED_SCALE, 16'hffff);
    set_reg(REG_P_GAIN, 16'd255);
    set_reg(REG_OUT_LIMIT, 16'd16383);
    set_reg(REG_POWER_LOW, 16'd1023);
    set_reg(REG_POWER_HIGH, 16'd1023);
    send_word(16'h7fff, 10'd0, POS_FRONT_CURVE, 16'h8000, 16'h7fff);
    send_word(16'h8000, 10'd1023, POS_BEHIND_CURVE, 16'h7fff, 16'h8000);
    send_word(16'sd16383, 10'd512, POS_UNUSED, 16'sd0, 16'sd0);
    send_word(-16'sd16383, 10'd0, POS_STRAIGHT, 16'sd0, 16'sd0);
    settle();
  endtask

  task automatic test_random_phases();
    int ms, sl, base, cmd, lvl, rpm, fm, bm, jit;
    logic [1:0] pos;
    for (int phase = 0; phase < RAND_PHASES; phase++) begin
      set_reg(REG_MAX_SPEED, with_junk(14, pick_val(16'(RST_MAX_SPEED), 16383)));
      set_reg(REG_SLEW_THRESH, with_junk(14, pick_val(16'(RST_SLEW_THRESH), 16383)));
      set_reg(REG_LAG_GAIN, pick_val(RST_LAG_GAIN, 65535));
      set_reg(REG_POWER_LOW, with_junk(10, pick_val(16'(RST_POWER_LOW), 1023)));
      set_reg(REG_POWER_HIGH, with_junk(10, pick_val(16'(RST_POWER_HIGH), 1023)));
      set_reg(REG_REDUCED_SCALE, pick_val(RST_REDUCED_SCALE, 65535));
      set_reg(REG_P_GAIN, with_junk(8, pick_val(16'(RST_P_GAIN), 255)));
      set_reg(REG_OUT_LIMIT, with_junk(14, pick_val(16'(RST_OUT_LIMIT), 16383)));
      src_idle = $urandom_range(0, 3) != 0;
      sink_idle = $urandom_range(0, 3) != 0;
      ms = int'(cfg.max_speed);
      sl = int'(cfg.slew);
      base = 0;
      lvl = $urandom_range(0, 1023);
      for (int n = 0; n < PHASE_WORDS; n++) begin
        if ($urandom_range(0, 11) == 0) begin
          case ($urandom_range(0, 3))
            0: base = $urandom_range(0, 65535) - 32768;
            1: base = $urandom_range(0, 2 * ms) - ms;
            2: base = ($urandom_range(0, 1) ? ms : -ms) + $urandom_range(0, 4) - 2;
            default: base = $urandom_range(0, 200) - 100;
          endcase
        end
        cmd = base;
        case ($urandom_range(0, 5))
          0: cmd = base + $urandom_range(0, 2 * sl + 2) - sl - 1;
          1: cmd = (tgt_q16 >>> 16) + ($urandom_range(0, 1) ? 1 : -1)
                   * (sl + $urandom_range(0, 2) - 1);
          default: ;
        endcase
        case ($urandom_range(0, 3))
          0: lvl = $urandom_range(0, 1023);
          1: lvl = int'(cfg.pwr_low) + $urandom_range(0, 4) - 2;
          2: lvl = int'(cfg.pwr_high) + $urandom_range(0, 4) - 2;
          default: lvl = lvl + $urandom_range(0, 40) - 20;
        endcase
        lvl = int'(clamp_lvl(lvl));
        pos = 2'($urandom_range(0, 3));
        rpm = tgt_q16 >>> 16;
        jit = $urandom_range(0, 128) - 64;
        if ($urandom_range(0, 3) == 0) begin
          fm = $urandom_range(0, 65535) - 32768;
          bm = $urandom_range(0, 65535) - 32768;
        end else begin
          fm = -rpm + jit;
          bm = rpm + $urandom_range(0, 128) - 64;
        end
        send_word(sat16(cmd), lvl[9:0], pos, sat16(fm), sat16(bm));
      end
      settle();
    end
  endtask

  initial begin : result_sink
    int gap;
    drive_out_if.ready <= 1'b0;
    while (rst) @(posedge clk);
    forever begin
      gap = sink_idle ? $urandom_range(0, 9) : 0;
      if (gap > 0) begin
        drive_out_if.ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      drive_out_if.ready <= 1'b1;
      do @(posedge clk); while (!(drive_out_if.valid && drive_out_if.ready));
    end
  end

  always @(posedge clk) begin : result_check
    drive_result_t want;
    if (!rst && drive_out_if.valid && drive_out_if.ready) begin
      if (pending_drives.size() == 0) begin
        $error("unexpected result word: front_drive %0d back_drive %0d",
               drive_out_if.front_drive, drive_out_if.back_drive);
        fail_cnt++;
      end else begin
        want = pending_drives.pop_front();
        results_seen++;
        if (drive_out_if.front_drive !== want.front) begin
          $error("front_drive mismatch: expected %0d, got %0d",
                 want.front, drive_out_if.front_drive);
          fail_cnt++;
        end
        if (drive_out_if.back_drive !== want.back) begin
          $error("back_drive mismatch: expected %0d, got %0d",
                 want.back, drive_out_if.back_drive);
          fail_cnt++;
        end
        if (drive_out_if.limiting_active !== want.limiting) begin
          $error("limiting_active mismatch: expected %0d, got %0d",
                 want.limiting, drive_out_if.limiting_active);
          fail_cnt++;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("Timed out after %0d cycles with %0d results outstanding",
               cycle_cnt, pending_drives.size());
      $display("FAIL");
      $finish;
    end
  end

  initial begin
    drive_in_if.valid <= 1'b0;
    drive_in_if.speed_command <= '0;
    drive_in_if.buffer_level <= '0;
    drive_in_if.track_position <= POS_STRAIGHT;
    drive_in_if.front_measured <= '0;
    drive_in_if.back_measured <= '0;
    wr_en <= 1'b0;
    wr_index <= REG_MAX_SPEED;
    wr_data <= '0;
    cfg.max_speed = RST_MAX_SPEED;
    cfg.slew = RST_SLEW_THRESH;
    cfg.lag_gain = RST_LAG_GAIN;
    cfg.pwr_low = RST_POWER_LOW;
    cfg.pwr_high = RST_POWER_HIGH;
    cfg.red_scale = RST_REDUCED_SCALE;
    cfg.p_gain = RST_P_GAIN;
    cfg.out_limit = RST_OUT_LIMIT;
    tgt_q16 = 0;
    limited = 1'b0;
    src_idle = 1'b0;
    sink_idle = 1'b0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_default_settings();
    test_crossed_thresholds();
    test_zero_limits();
    test_full_scale();
    test_random_phases();

    settle();
    repeat (3 * LATENCY) @(posedge clk);
    $display("Sent %0d words and checked %0d results across %0d register writes,",
             words_sent, results_seen, reg_writes);
    $display("covering curves, power hysteresis, slew lag and drive saturation.");
    if (fail_cnt == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

// File: files.f
hw/rtl/twdsl_pkg.sv
hw/rtl/twdsl_intf.sv
hw/rtl/twdsl_ctrl.sv
hw/rtl/twdsl_dp.sv
hw/rtl/two_wheel_drive_speed_loop.sv
hw/rtl/twdsl_chk.sv
tb/tb_two_wheel_drive_speed_loop.sv
